@@ design/rpn_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_pkg: shared types, codes and constants of the RPN evaluator
// Token codes, error codes, command word, fixed-point constants and the
// CORDIC arctangent table.
// ----------------------------------------------------------------------------
package rpn_pkg;

	localparam int STACK_DEPTH  = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int CNT_W        = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W       = $clog2(STACK_DEPTH);
	localparam int STEP_W       = $clog2(CORDIC_STEPS);

	// token kinds
	localparam logic [3:0] FN_CONST = 4'd0;
	localparam logic [3:0] FN_X     = 4'd1;
	localparam logic [3:0] FN_Y     = 4'd2;
	localparam logic [3:0] FN_Z     = 4'd3;
	localparam logic [3:0] FN_ADD   = 4'd4;
	localparam logic [3:0] FN_SUB   = 4'd5;
	localparam logic [3:0] FN_MUL   = 4'd6;
	localparam logic [3:0] FN_DIV   = 4'd7;
	localparam logic [3:0] FN_SIN   = 4'd8;
	localparam logic [3:0] FN_COS   = 4'd9;
	localparam logic [3:0] FN_TAN   = 4'd10;

	// error codes
	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_BINARY  = 3'd1;
	localparam logic [2:0] ERR_UNARY   = 3'd2;
	localparam logic [2:0] ERR_UNKNOWN = 3'd3;
	localparam logic [2:0] ERR_SINGLE  = 3'd4;
	localparam logic [2:0] ERR_OVERFL  = 3'd5;
	localparam logic [2:0] ERR_DIV0    = 3'd6;

	// Q16 angle constants
	localparam logic signed [21:0] Q_TWO_PI  = 22'sd411775;
	localparam logic signed [21:0] Q_PI      = 22'sd205887;
	localparam logic signed [21:0] Q_HALF_PI = 22'sd102944;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic signed [31:0] MAX32 = 32'sh7FFFFFFF;
	localparam logic signed [31:0] MIN32 = 32'sh80000000;

	typedef enum logic [1:0] {
		CL_PUSH,
		CL_BIN,
		CL_UNA,
		CL_BAD
	} cls_t;

	typedef struct packed {
		cls_t               cls;
		logic [3:0]         func;
		logic signed [31:0] value;
		logic               last;
	} cmd_t;

	function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'(MAX32))
			r = MAX32;
		else if (v < 64'(MIN32))
			r = MIN32;
		else
			r = v[31:0];
		return r;
	endfunction

	// magnitude of a signed 32-bit value, 2^31 included
	function automatic logic [31:0] mag32(input logic signed [31:0] a);
		logic [31:0] r;
		r = a[31] ? (~a + 32'd1) : a;
		return r;
	endfunction

	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'd843314857;
			5'd1:  r = 32'd497837830;
			5'd2:  r = 32'd263043837;
			5'd3:  r = 32'd133525159;
			5'd4:  r = 32'd67021687;
			5'd5:  r = 32'd33543516;
			5'd6:  r = 32'd16775851;
			5'd7:  r = 32'd8388438;
			5'd8:  r = 32'd4194283;
			5'd9:  r = 32'd2097149;
			5'd10: r = 32'd1048576;
			5'd11: r = 32'd524288;
			5'd12: r = 32'd262144;
			5'd13: r = 32'd131072;
			5'd14: r = 32'd65536;
			5'd15: r = 32'd32768;
			5'd16: r = 32'd16384;
			5'd17: r = 32'd8192;
			5'd18: r = 32'd4096;
			5'd19: r = 32'd2048;
			5'd20: r = 32'd1024;
			5'd21: r = 32'd512;
			5'd22: r = 32'd256;
			5'd23: r = 32'd128;
			5'd24: r = 32'd64;
			5'd25: r = 32'd32;
			5'd26: r = 32'd16;
			5'd27: r = 32'd8;
			5'd28: r = 32'd4;
			5'd29: r = 32'd2;
			5'd30: r = 32'd1;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

@@ design/rpn_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_tok_if / rpn_res_if: token and result channels
// Valid/ready channels; a request moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface rpn_tok_if;
	logic               valid;
	logic               ready;
	logic [3:0]         func;
	logic signed [31:0] const_value;
	logic signed [31:0] coord_x;
	logic signed [31:0] coord_y;
	logic signed [31:0] coord_z;
	logic               last_token;

	modport source (output valid, func, const_value, coord_x, coord_y, coord_z,
		last_token, input ready);
	modport sink (input valid, func, const_value, coord_x, coord_y, coord_z,
		last_token, output ready);
endinterface

interface rpn_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic [2:0]         error_code;

	modport source (output valid, value, error_code, input ready);
	modport sink (input valid, value, error_code, output ready);
endinterface
`default_nettype wire

@@ design/rpn_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_front: token intake
// Classifies each token, picks its push operand and queues it (two entries).
// ----------------------------------------------------------------------------
module rpn_front import rpn_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rpn_tok_if.sink    tok,
	output cmd_t       cmd,
	output logic       cmd_valid,
	input  wire logic  cmd_take
);

	cmd_t       q_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	cmd_t       in_cmd;
	logic       acc;

	always_comb begin
		in_cmd.func = tok.func;
		in_cmd.last = tok.last_token;
		case (tok.func)
			FN_X:    in_cmd.value = tok.coord_x;
			FN_Y:    in_cmd.value = tok.coord_y;
			FN_Z:    in_cmd.value = tok.coord_z;
			default: in_cmd.value = tok.const_value;
		endcase
		if (tok.func inside {FN_CONST, FN_X, FN_Y, FN_Z})
			in_cmd.cls = CL_PUSH;
		else if (tok.func inside {[FN_ADD:FN_DIV]})
			in_cmd.cls = CL_BIN;
		else if (tok.func inside {[FN_SIN:FN_TAN]})
			in_cmd.cls = CL_UNA;
		else
			in_cmd.cls = CL_BAD;
	end

	assign tok.ready = (cnt_q != 2'd2);
	assign acc       = tok.valid && tok.ready;
	assign cmd       = q_q[rp_q];
	assign cmd_valid = (cnt_q != 2'd0);

	always_ff @(posedge clk) begin
		if (acc)
			q_q[wp_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (acc)
				wp_q <= ~wp_q;
			if (cmd_take)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(acc) - 2'(cmd_take);
		end
	end

endmodule
`default_nettype wire

@@ design/rpn_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_back: execution unit
// Value stack memory, sequencer, multiplier, bit-serial divider, angle
// reduction by reciprocal multiplication, CORDIC and the result register.
// ----------------------------------------------------------------------------
module rpn_back import rpn_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cmd_t  cmd,
	input  wire logic  cmd_valid,
	output logic       cmd_take,
	rpn_res_if.source  res
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RDA  = 4'd1;
	localparam logic [3:0] S_RDB  = 4'd2;
	localparam logic [3:0] S_EXE  = 4'd3;
	localparam logic [3:0] S_MUL  = 4'd4;
	localparam logic [3:0] S_DIV  = 4'd5;
	localparam logic [3:0] S_DFIN = 4'd6;
	localparam logic [3:0] S_CORD = 4'd7;
	localparam logic [3:0] S_CFIN = 4'd8;
	localparam logic [3:0] S_PUSH = 4'd9;
	localparam logic [3:0] S_END  = 4'd10;
	localparam logic [3:0] S_OUT  = 4'd11;
	localparam logic [3:0] S_RED0 = 4'd12;
	localparam logic [3:0] S_RED1 = 4'd13;
	localparam logic [3:0] S_RED2 = 4'd14;

	localparam int DIV_STEPS = 48;

	// floor(2^40 / two_pi_q16); quotient estimate is at most one low
	localparam logic [21:0] RECIP_2PI = 22'd2670175;

	logic [3:0]         state_q;
	logic [CNT_W-1:0]   count_q;
	logic [2:0]         perr_q;
	cmd_t               cur_q;
	logic signed [31:0] opa_q;
	logic signed [31:0] opb_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] res_q;

	// stack memory
	logic signed [31:0] mem [STACK_DEPTH];
	logic signed [31:0] rd_q;
	logic [ADDR_W-1:0]  rd_addr;
	logic               we;
	logic signed [31:0] wd;

	// divider
	logic [47:0] num_q;
	logic [47:0] quo_q;
	logic [33:0] rem_q;
	logic [33:0] den_q;
	logic [5:0]  dcnt_q;
	logic        dneg_q;
	logic        dmod_q;
	logic [33:0] rem_sh;
	logic        rem_ge;
	logic signed [31:0] div_res;

	// angle reduction: |a| mod 2*pi
	logic [31:0] mag_q;
	logic [53:0] rprod_q;
	logic [32:0] red_sub;
	logic [33:0] red_rem;

	// cordic
	logic signed [33:0] cx_q;
	logic signed [33:0] cy_q;
	logic signed [32:0] cz_q;
	logic [STEP_W-1:0]  cit_q;
	logic               negc_q;
	logic               aneg_q;
	logic signed [32:0] at;

	// angle fold, from the reduced remainder
	logic signed [21:0] r0;
	logic signed [21:0] r1;
	logic signed [21:0] r2;
	logic               fold;
	logic signed [35:0] zt;

	// cordic finish
	logic signed [33:0] cval;
	logic [33:0]        cy_mag;
	logic [33:0]        cv_mag;
	logic signed [34:0] sin_r;
	logic signed [34:0] cos_r;

	// binary ops
	logic signed [32:0] sum;
	logic signed [32:0] dif;

	logic [3:0] after;
	logic       exec_ok;
	logic       load_out;

	// result register
	logic               ov_q;
	logic signed [31:0] oval_q;
	logic [2:0]         oerr_q;

	// ---------------- memory
	always_comb begin
		case (state_q)
			S_IDLE:  rd_addr = ADDR_W'(count_q - CNT_W'(1));
			S_RDA:   rd_addr = ADDR_W'(count_q - CNT_W'(2));
			default: rd_addr = '0;
		endcase
		we = ((state_q == S_IDLE) && cmd_valid && (perr_q == ERR_NONE) &&
			(cmd.cls == CL_PUSH) && (count_q < CNT_W'(STACK_DEPTH))) ||
			((state_q == S_PUSH) && (count_q < CNT_W'(STACK_DEPTH)));
		wd = (state_q == S_PUSH) ? res_q : cmd.value;
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[count_q[ADDR_W-1:0]] <= wd;
		rd_q <= mem[rd_addr];
	end

	// ---------------- datapath helpers
	always_comb begin
		rem_sh = {rem_q[32:0], num_q[47]};
		rem_ge = (rem_sh >= den_q);
		if (!dneg_q)
			div_res = (quo_q > 48'h7FFFFFFF) ? MAX32 : $signed(quo_q[31:0]);
		else
			div_res = (quo_q > 48'h80000000) ? MIN32 : $signed(~quo_q[31:0] + 32'd1);

		red_sub = rprod_q[53:40] * 19'(Q_TWO_PI);
		red_rem = 34'(mag_q) - 34'(red_sub);

		r0 = $signed(rem_q[21:0]);
		if (aneg_q && (rem_q != '0))
			r0 = Q_TWO_PI - r0;
		r1 = (r0 > Q_PI) ? (r0 - Q_TWO_PI) : r0;
		fold = 1'b1;
		if (r1 > Q_HALF_PI)
			r2 = Q_PI - r1;
		else if (r1 < -Q_HALF_PI)
			r2 = -Q_PI - r1;
		else begin
			r2   = r1;
			fold = 1'b0;
		end
		zt = 36'(r2) <<< 14;

		at = $signed({1'b0, atan_q30(5'(cit_q))});

		cval   = negc_q ? -cx_q : cx_q;
		cy_mag = cy_q[33] ? (~cy_q + 34'd1) : cy_q;
		cv_mag = cval[33] ? (~cval + 34'd1) : cval;
		sin_r  = (35'(cy_q) + 35'sd8192) >>> 14;
		cos_r  = (35'(cval) + 35'sd8192) >>> 14;

		sum = 33'(opa_q) + 33'(opb_q);
		dif = 33'(opa_q) - 33'(opb_q);

		after = cur_q.last ? S_END : S_IDLE;

		exec_ok = (perr_q == ERR_NONE) &&
			(((cmd.cls == CL_BIN) && (count_q >= CNT_W'(2))) ||
			((cmd.cls == CL_UNA) && (count_q >= CNT_W'(1))));
		load_out = (state_q == S_OUT) && (!ov_q || res.ready);
	end

	assign cmd_take = (state_q == S_IDLE) && cmd_valid;

	assign res.valid      = ov_q;
	assign res.value      = oval_q;
	assign res.error_code = oerr_q;

	// ---------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			perr_q  <= ERR_NONE;
			ov_q    <= 1'b0;
		end else begin
			if (load_out)
				ov_q <= 1'b1;
			else if (ov_q && res.ready)
				ov_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cur_q   <= cmd;
						state_q <= exec_ok ? S_RDA : (cmd.last ? S_END : S_IDLE);
						if (perr_q == ERR_NONE) begin
							case (cmd.cls)
								CL_PUSH: begin
									if (count_q < CNT_W'(STACK_DEPTH))
										count_q <= count_q + CNT_W'(1);
									else
										perr_q <= ERR_OVERFL;
								end
								CL_BIN: begin
									if (count_q < CNT_W'(2))
										perr_q <= ERR_BINARY;
								end
								CL_UNA: begin
									if (count_q < CNT_W'(1))
										perr_q <= ERR_UNARY;
								end
								default: perr_q <= ERR_UNKNOWN;
							endcase
						end
					end
				end
				S_RDA: begin
					opb_q <= rd_q;
					if (cur_q.cls == CL_BIN) begin
						count_q <= count_q - CNT_W'(2);
						state_q <= S_RDB;
					end else begin
						// angle reduction: |a| mod 2*pi by reciprocal multiply
						count_q <= count_q - CNT_W'(1);
						mag_q   <= mag32(rd_q);
						dmod_q  <= 1'b1;
						aneg_q  <= rd_q[31];
						state_q <= S_RED0;
					end
				end
				S_RED0: begin
					rprod_q <= mag_q * RECIP_2PI;
					state_q <= S_RED1;
				end
				S_RED1: begin
					rem_q   <= red_rem;
					state_q <= S_RED2;
				end
				S_RED2: begin
					if (rem_q >= 34'(Q_TWO_PI))
						rem_q <= rem_q - 34'(Q_TWO_PI);
					state_q <= S_DFIN;
				end
				S_RDB: begin
					opa_q   <= rd_q;
					state_q <= S_EXE;
				end
				S_EXE: begin
					case (cur_q.func)
						FN_ADD: begin
							res_q   <= sat64(64'(sum));
							state_q <= S_PUSH;
						end
						FN_SUB: begin
							res_q   <= sat64(64'(dif));
							state_q <= S_PUSH;
						end
						FN_MUL: begin
							prod_q  <= opa_q * opb_q;
							state_q <= S_MUL;
						end
						default: begin
							if (opb_q == '0) begin
								if (perr_q == ERR_NONE)
									perr_q <= ERR_DIV0;
								res_q <= (opa_q > 0) ? MAX32 :
									((opa_q < 0) ? MIN32 : '0);
								state_q <= S_PUSH;
							end else begin
								num_q   <= {mag32(opa_q), 16'd0};
								den_q   <= 34'(mag32(opb_q));
								rem_q   <= '0;
								dcnt_q  <= '0;
								dmod_q  <= 1'b0;
								dneg_q  <= opa_q[31] ^ opb_q[31];
								state_q <= S_DIV;
							end
						end
					endcase
				end
				S_MUL: begin
					res_q   <= sat64(prod_q >>> 16);
					state_q <= S_PUSH;
				end
				S_DIV: begin
					rem_q  <= rem_ge ? (rem_sh - den_q) : rem_sh;
					quo_q  <= {quo_q[46:0], rem_ge};
					num_q  <= {num_q[46:0], 1'b0};
					dcnt_q <= dcnt_q + 6'd1;
					if (dcnt_q == 6'(DIV_STEPS - 1))
						state_q <= S_DFIN;
				end
				S_DFIN: begin
					if (dmod_q) begin
						cx_q    <= CORDIC_GAIN;
						cy_q    <= '0;
						cz_q    <= zt[32:0];
						negc_q  <= fold;
						cit_q   <= '0;
						state_q <= S_CORD;
					end else begin
						res_q   <= div_res;
						state_q <= S_PUSH;
					end
				end
				S_CORD: begin
					if (!cz_q[32]) begin
						cx_q <= cx_q - (cy_q >>> cit_q);
						cy_q <= cy_q + (cx_q >>> cit_q);
						cz_q <= cz_q - at;
					end else begin
						cx_q <= cx_q + (cy_q >>> cit_q);
						cy_q <= cy_q - (cx_q >>> cit_q);
						cz_q <= cz_q + at;
					end
					cit_q <= cit_q + STEP_W'(1);
					if (cit_q == STEP_W'(CORDIC_STEPS - 1))
						state_q <= S_CFIN;
				end
				S_CFIN: begin
					case (cur_q.func)
						FN_SIN: begin
							res_q   <= sat64(64'(sin_r));
							state_q <= S_PUSH;
						end
						FN_COS: begin
							res_q   <= sat64(64'(cos_r));
							state_q <= S_PUSH;
						end
						default: begin
							if (cval == '0) begin
								if (perr_q == ERR_NONE)
									perr_q <= ERR_DIV0;
								res_q <= (cy_q > 0) ? MAX32 :
									((cy_q < 0) ? MIN32 : '0);
								state_q <= S_PUSH;
							end else begin
								num_q   <= {cy_mag[31:0], 16'd0};
								den_q   <= cv_mag;
								rem_q   <= '0;
								dcnt_q  <= '0;
								dmod_q  <= 1'b0;
								dneg_q  <= cy_q[33] ^ cval[33];
								state_q <= S_DIV;
							end
						end
					endcase
				end
				S_PUSH: begin
					if (count_q < CNT_W'(STACK_DEPTH))
						count_q <= count_q + CNT_W'(1);
					else if (perr_q == ERR_NONE)
						perr_q <= ERR_OVERFL;
					state_q <= after;
				end
				S_END: begin
					if ((perr_q == ERR_NONE) && (count_q != CNT_W'(1)))
						perr_q <= ERR_SINGLE;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (load_out) begin
						oval_q  <= (perr_q == ERR_NONE) ? rd_q : '0;
						oerr_q  <= perr_q;
						perr_q  <= ERR_NONE;
						count_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ design/rpn_expression_evaluator_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_expression_evaluator_top: postfix expression evaluator
// Evaluates a token stream in Q15.16 and returns one result per expression.
// ----------------------------------------------------------------------------
// Tokens enter on tok, one request each, and are held in a two-entry queue
// so the producer keeps going while the execution unit works. Each token is
// executed against a 16-entry value stack held in a memory with one read
// port, so operands are fetched one per cycle. Once a token is at the head
// of the queue, div yields one quotient bit per cycle over 48 bits, sin/cos
// run angle reduction by reciprocal multiplication plus 16 CORDIC steps,
// and tan is sin/cos followed by a division. The token marked last passes
// through S_END and S_OUT and returns value and error_code on res; a
// finished result waits in the output register while the next expression is
// already being taken in. After the first error of an expression, the
// remaining tokens are dropped and value reads zero. There is no clearing
// pass after reset: stack entries are only read after they were pushed.
module rpn_expression_evaluator_top import rpn_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	rpn_tok_if.sink   tok,
	rpn_res_if.source res
);

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_take;

	// intake and classify
	rpn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok       (tok),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take)
	);

	// stack, arithmetic, result register
	rpn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.res       (res)
	);

endmodule
`default_nettype wire

@@ design/rpn_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_checker: port-level checks of the evaluator
// Result codes, zeroed value on error, held result, and results only for
// accepted last tokens.
// ----------------------------------------------------------------------------
module rpn_checker import rpn_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        tok_valid,
	input wire logic        tok_ready,
	input wire logic        tok_last,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [31:0] res_value,
	input wire logic [2:0]  res_err
);

	logic [2:0] pend_q;
	logic       in_last;
	logic       out_acc;

	assign in_last = tok_valid && tok_ready && tok_last;
	assign out_acc = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else
			pend_q <= pend_q + 3'(in_last) - 3'(out_acc);
	end

	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_err <= ERR_DIV0))
		else $error("error_code out of range");

	a_zero_on_err: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res_err != ERR_NONE)) |-> (res_value == '0))
		else $error("value not zero on error");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res_value) &&
		$stable(res_err)))
		else $error("stalled result changed");

	a_owed: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> (pend_q != '0))
		else $error("result without a closed expression");

endmodule

bind rpn_expression_evaluator_top rpn_checker u_rpn_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.tok_valid (tok.valid),
	.tok_ready (tok.ready),
	.tok_last  (tok.last_token),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_value (res.value),
	.res_err   (res.error_code)
);
`default_nettype wire
